/* rtl/core/ledb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ledb_pkg;

    localparam logic [1:0] PAT_OFF     = 2'd0;
    localparam logic [1:0] PAT_STEADY  = 2'd1;
    localparam logic [1:0] PAT_BREATHE = 2'd2;
    localparam logic [1:0] PAT_BLINK   = 2'd3;

    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [8:0] LEVEL_NONE   = 9'd256;
    localparam logic [7:0] BRIGHT_RESET = 8'd90;

    localparam logic [5:0] DIV_ITERS_PHASE = 6'd32;
    localparam logic [5:0] DIV_ITERS_RAMP  = 6'd19;

    typedef struct packed {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [1:0]  pat;
        logic [11:0] period;
        logic [10:0] half;
        logic [9:0]  quarter;
        logic [7:0]  floor_lvl;
    } t_fx;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [11:0] divisor;
        logic [5:0]  iters;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [11:0] rem;
        logic [31:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic       valid;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] level;
    } t_res;

    function automatic t_fx fx_lookup(input logic [2:0] status);
        t_fx e;
        case (status)
            3'd1:    e = '{8'd40, 8'd110, 8'd255, PAT_BREATHE, 12'd2600, 11'd1300, 10'd650, 8'd40};
            3'd2:    e = '{8'd40, 8'd110, 8'd255, PAT_BREATHE, 12'd1500, 11'd750, 10'd375, 8'd60};
            3'd3:    e = '{8'd255, 8'd45, 8'd45, PAT_BREATHE, 12'd2200, 11'd1100, 10'd550, 8'd30};
            3'd4:    e = '{8'd30, 8'd205, 8'd95, PAT_BREATHE, 12'd3200, 11'd1600, 10'd800, 8'd130};
            3'd5:    e = '{8'd255, 8'd40, 8'd40, PAT_BLINK, 12'd900, 11'd450, 10'd225, 8'd0};
            3'd6:    e = '{8'd255, 8'd150, 8'd40, PAT_STEADY, 12'd1000, 11'd500, 10'd250, 8'd0};
            default: e = '{8'd0, 8'd0, 8'd0, PAT_OFF, 12'd1000, 11'd500, 10'd250, 8'd0};
        endcase
        return e;
    endfunction

    // exact floor(x / 255) for any x up to 65279, where the quotient fits in 8 bits
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        logic [16:0] s;
        t = {1'b0, x} + 17'd1;
        s = t + (t >> 8);
        return s[15:8];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ledb_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module ledb_div
    import ledb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [11:0] r_rem, n_rem;
    logic [31:0] r_dq, n_dq;
    logic [11:0] r_div, n_div;
    logic [12:0] trial;
    logic [12:0] diff;
    logic        ge;

    // restoring division, one quotient bit per cycle shifted into the dividend register
    always_comb begin
        trial  = {r_rem, r_dq[31]};
        diff   = trial - {1'b0, r_div};
        ge     = (trial >= {1'b0, r_div});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dq   = r_dq;
        n_div  = r_div;
        if (r_busy) begin
            n_rem = ge ? diff[11:0] : trial[11:0];
            n_dq  = {r_dq[30:0], ge};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.iters;
            n_rem  = '0;
            n_dq   = i_req.dividend;
            n_div  = i_req.divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dq  <= n_dq;
        r_div <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
    assign o_rsp.quo  = r_dq;

endmodule

`default_nettype wire

/* rtl/core/ledb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ledb_ctrl
    import ledb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [2:0]  i_status,
    input  wire logic [31:0] i_now,
    input  wire logic [7:0]  i_bright,
    output t_div_req         o_div_req,
    input  wire t_div_rsp    i_div_rsp,
    output t_res             o_res,
    input  wire logic        i_res_ready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PHASE = 4'd1;
    localparam logic [3:0] S_FACT  = 4'd2;
    localparam logic [3:0] S_TMUL  = 4'd3;
    localparam logic [3:0] S_FDIV  = 4'd4;
    localparam logic [3:0] S_LMUL  = 4'd5;
    localparam logic [3:0] S_LEVEL = 4'd6;
    localparam logic [3:0] S_C0    = 4'd7;
    localparam logic [3:0] S_C1    = 4'd8;
    localparam logic [3:0] S_C2    = 4'd9;
    localparam logic [3:0] S_C3    = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]  r_state, n_state;
    logic [2:0]  r_status, n_status;
    logic [31:0] r_start, n_start;
    logic        r_running, n_running;
    logic [8:0]  r_last, n_last;
    logic [11:0] r_phase, n_phase;
    logic [7:0]  r_factor, n_factor;
    logic [7:0]  r_q, n_q;
    logic [18:0] r_prod, n_prod;
    logic [7:0]  r_red, n_red;
    logic [7:0]  r_green, n_green;
    logic [7:0]  r_blue, n_blue;

    t_fx         cur;
    t_fx         nx;
    logic        accept;
    logic        changed;
    logic [11:0] travel;
    logic [7:0]  mul_a;
    logic [10:0] mul_b;
    logic [8:0]  fsum;
    logic [7:0]  level;
    logic [8:0]  lp4;
    logic [8:0]  q;
    logic [7:0]  prod255;

    always_comb begin
        cur     = fx_lookup(r_status);
        nx      = fx_lookup(i_status);
        accept  = i_in_valid && (r_state == S_IDLE);
        changed = (nx.pat != cur.pat) || (nx.r != cur.r) || (nx.g != cur.g) ||
                  (nx.b != cur.b);
        travel  = (r_phase < {1'b0, cur.half}) ? r_phase : (cur.period - r_phase);
        fsum    = {1'b0, cur.floor_lvl} + {1'b0, i_div_rsp.quo[7:0]};
        prod255 = div255(r_prod[15:0]);
        level   = prod255;
        lp4     = {1'b0, level} + 9'd4;
        q       = lp4[8] ? 9'd255 : {1'b0, lp4[7:3], 3'b000};
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_FACT: begin
                mul_a = 8'd255 - cur.floor_lvl;
                mul_b = travel[10:0];
            end
            S_LMUL: begin
                mul_a = i_bright;
                mul_b = {3'b000, r_factor};
            end
            S_C0: begin
                mul_a = cur.r;
                mul_b = {3'b000, r_q};
            end
            S_C1: begin
                mul_a = cur.g;
                mul_b = {3'b000, r_q};
            end
            S_C2: begin
                mul_a = cur.b;
                mul_b = {3'b000, r_q};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        o_div_req.start    = 1'b0;
        o_div_req.dividend = i_now - r_start;
        o_div_req.divisor  = cur.period;
        o_div_req.iters    = DIV_ITERS_PHASE;
        if (r_state == S_TMUL) begin
            o_div_req.start    = 1'b1;
            o_div_req.dividend = {r_prod, 13'd0};
            o_div_req.divisor  = {1'b0, cur.half};
            o_div_req.iters    = DIV_ITERS_RAMP;
        end else if (accept && (i_action == ACT_TICK) && r_running) begin
            o_div_req.start = 1'b1;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_status  = r_status;
        n_start   = r_start;
        n_running = r_running;
        n_last    = r_last;
        n_phase   = r_phase;
        n_factor  = r_factor;
        n_q       = r_q;
        n_prod    = r_prod;
        n_red     = r_red;
        n_green   = r_green;
        n_blue    = r_blue;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_SET: begin
                            n_status = i_status;
                            if (changed) begin
                                n_start = i_now;
                                n_last  = LEVEL_NONE;
                            end
                        end
                        ACT_START: begin
                            n_start   = i_now;
                            n_running = 1'b1;
                            n_last    = {1'b0, i_bright};
                            n_q       = i_bright;
                            n_state   = S_C0;
                        end
                        ACT_TICK: begin
                            if (r_running) begin
                                n_state = S_PHASE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PHASE: begin
                if (i_div_rsp.done) begin
                    n_phase = i_div_rsp.rem;
                    n_state = S_FACT;
                end
            end
            S_FACT: begin
                n_state = S_LMUL;
                case (cur.pat)
                    PAT_STEADY:  n_factor = 8'd255;
                    PAT_BLINK:   n_factor = (r_phase < {2'b00, cur.quarter}) ? 8'd255 : 8'd0;
                    PAT_BREATHE: begin
                        n_prod  = 19'(mul_a) * 19'(mul_b);
                        n_state = S_TMUL;
                    end
                    default:     n_factor = 8'd0;
                endcase
            end
            S_TMUL: begin
                n_state = S_FDIV;
            end
            S_FDIV: begin
                if (i_div_rsp.done) begin
                    n_factor = fsum[8] ? 8'd255 : fsum[7:0];
                    n_state  = S_LMUL;
                end
            end
            S_LMUL: begin
                n_prod  = 19'(mul_a) * 19'(mul_b);
                n_state = S_LEVEL;
            end
            S_LEVEL: begin
                if (q == r_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_last  = q;
                    n_q     = q[7:0];
                    n_state = S_C0;
                end
            end
            S_C0: begin
                n_prod  = 19'(mul_a) * 19'(mul_b);
                n_state = S_C1;
            end
            S_C1: begin
                n_red   = prod255;
                n_prod  = 19'(mul_a) * 19'(mul_b);
                n_state = S_C2;
            end
            S_C2: begin
                n_green = prod255;
                n_prod  = 19'(mul_a) * 19'(mul_b);
                n_state = S_C3;
            end
            S_C3: begin
                n_blue  = prod255;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_status  <= '0;
            r_start   <= '0;
            r_running <= 1'b0;
            r_last    <= LEVEL_NONE;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_start   <= n_start;
            r_running <= n_running;
            r_last    <= n_last;
        end
        r_phase  <= n_phase;
        r_factor <= n_factor;
        r_q      <= n_q;
        r_prod   <= n_prod;
        r_red    <= n_red;
        r_green  <= n_green;
        r_blue   <= n_blue;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_OUT);
    assign o_res.red   = r_red;
    assign o_res.green = r_green;
    assign o_res.blue  = r_blue;
    assign o_res.level = r_q;

endmodule

`default_nettype wire

/* rtl/core/led_breathing_effect_engine_unit.sv */
// LED breathing effect engine: one RGB colour from a status code.
// Slave stream takes one transaction per command: action 0 sets the status
// (no result), action 1 starts the effect (one result at the set brightness),
// action 2 is a millisecond tick (one result only when the quantised level
// changes). Action 3 and ticks before a start are dropped without a result.
// Master stream carries red, green, blue and the applied level.
// Brightness is written through the cfg channel, which is always ready; the
// user must write it only while no transaction is in flight, which the block
// itself does not enforce. A set-status transaction leaves the engine ready.
// A start paints the colour at the set brightness. A tick takes the phase
// modulo on the divider, forms the pattern factor (breathe adds a ramp
// division) and scales and quantises the level; only a changed level is
// painted. The bit-serial divider runs 32 steps for the phase modulo, 19 for
// the breathe ramp. One transaction is worked on at a time; s_axis_tready is
// low until it completes. The result sits in an output register, so the next
// transaction is taken while it waits; a stalled master holds the engine only
// when a second result is ready to go out.
// Reset (i_rst_n low, synchronous): brightness 90, status idle, not started,
// no level emitted yet, output empty.
`timescale 1ns / 1ps
`default_nettype none

module led_breathing_effect_engine_unit
    import ledb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // action[1:0], pet_status[4:2], now_ms[36:5]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // red_out, green_out, blue_out, level_out
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    logic [7:0]  r_bright;
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        res_ready;
    t_div_req    div_req;
    t_div_rsp    div_rsp;
    t_res        res;

    ledb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ledb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (s_axis_tdata[1:0]),
        .i_status    (s_axis_tdata[4:2]),
        .i_now       (s_axis_tdata[36:5]),
        .i_bright    (r_bright),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright    <= BRIGHT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bright <= i_cfg_data;
            end
            if (res.valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res.valid && res_ready) begin
            r_out_data <= {res.level, res.blue, res.green, res.red};
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_set_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == ACT_SET) |=> s_axis_tready)
        else $error("set status did not complete in one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == ACT_START) |=> !s_axis_tready)
        else $error("start transaction did not occupy the engine");

    a_dark_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[31:24] == 8'd0) |-> (m_axis_tdata[23:0] == 24'd0))
        else $error("colour output non-zero at level zero");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && !res_ready) |=> r_out_valid)
        else $error("pending result lost");
`endif

endmodule

`default_nettype wire

/* tb/led_colour_checker.sv */
`timescale 1ns / 1ps

module led_colour_checker
    import ledb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  wire logic        i_cmd_ready,
    input  wire logic [39:0] i_cmd_data,  // action[1:0], pet_status[4:2], now_ms[36:5]
    input  wire logic        i_px_valid,
    input  wire logic        i_px_ready,
    input  wire logic [31:0] i_px_data,   // red_out, green_out, blue_out, level_out
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,
    output int               o_fail_count,
    output int               o_due_count
);

    typedef struct packed {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [1:0]  pat;
        logic [11:0] period;
        logic [7:0]  flr;
    } t_effect;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] level;
    } t_pixel;

    logic [7:0]  bright;
    logic [2:0]  status;
    logic [31:0] start_ms;
    logic        running;
    logic [8:0]  last_lvl;
    t_pixel      due_px[$];

    function automatic t_effect effect_of(input logic [2:0] st);
        t_effect e;
        case (st)
            3'd1:    e = {8'd40, 8'd110, 8'd255, PAT_BREATHE, 12'd2600, 8'd40};
            3'd2:    e = {8'd40, 8'd110, 8'd255, PAT_BREATHE, 12'd1500, 8'd60};
            3'd3:    e = {8'd255, 8'd45, 8'd45, PAT_BREATHE, 12'd2200, 8'd30};
            3'd4:    e = {8'd30, 8'd205, 8'd95, PAT_BREATHE, 12'd3200, 8'd130};
            3'd5:    e = {8'd255, 8'd40, 8'd40, PAT_BLINK, 12'd900, 8'd0};
            3'd6:    e = {8'd255, 8'd150, 8'd40, PAT_STEADY, 12'd1000, 8'd0};
            default: e = {8'd0, 8'd0, 8'd0, PAT_OFF, 12'd1000, 8'd0};
        endcase
        return e;
    endfunction

    function automatic int unsigned factor_at(input t_effect e, input int unsigned phase);
        int unsigned half;
        int unsigned travel;
        int unsigned f;
        half = e.period / 2;
        case (e.pat)
            PAT_STEADY: f = 255;
            PAT_BREATHE: begin
                travel = (phase < half) ? phase : e.period - phase;
                if (half == 0) begin
                    f = 255;
                end else begin
                    f = e.flr + (255 - e.flr) * travel / half;
                    if (f > 255) f = 255;
                end
            end
            PAT_BLINK: f = (phase < e.period / 4) ? 255 : 0;
            default: f = 0;
        endcase
        return f;
    endfunction

    function automatic t_pixel paint(input t_effect e, input int unsigned lvl);
        t_pixel p;
        p.red   = 8'((e.r * lvl) / 255);
        p.green = 8'((e.g * lvl) / 255);
        p.blue  = 8'((e.b * lvl) / 255);
        p.level = 8'(lvl);
        return p;
    endfunction

    task automatic predict_pixel(input logic [39:0] d);
        logic [1:0]  act;
        logic [2:0]  st;
        logic [31:0] now;
        logic [31:0] elapsed;
        t_effect     cur;
        t_effect     nxt;
        int unsigned lvl;
        int unsigned q;
        act = d[1:0];
        st  = d[4:2];
        now = d[36:5];
        cur = effect_of(status);
        case (act)
            ACT_SET: begin
                nxt = effect_of(st);
                if (nxt.pat != cur.pat || nxt.r != cur.r || nxt.g != cur.g || nxt.b != cur.b)
                begin
                    start_ms = now;
                    last_lvl = LEVEL_NONE;
                end
                status = st;
            end
            ACT_START: begin
                start_ms = now;
                running  = 1'b1;
                last_lvl = {1'b0, bright};
                due_px.push_back(paint(cur, bright));
            end
            ACT_TICK: begin
                if (running) begin
                    elapsed = now - start_ms;
                    lvl = bright * factor_at(cur, elapsed % cur.period) / 255;
                    q = (lvl + 4) / 8 * 8;
                    if (q > 255) q = 255;
                    if (q != last_lvl) begin
                        last_lvl = 9'(q);
                        due_px.push_back(paint(cur, q));
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel exp_px;
        if (!i_rst_n) begin
            bright       = BRIGHT_RESET;
            status       = 3'd0;
            start_ms     = 32'd0;
            running      = 1'b0;
            last_lvl     = LEVEL_NONE;
            o_fail_count = 0;
            due_px.delete();
        end else begin
            if (i_px_valid && i_px_ready) begin
                if (due_px.size() == 0) begin
                    $error("unexpected transaction on output: %h", i_px_data);
                    o_fail_count++;
                end else begin
                    exp_px = due_px.pop_front();
                    check_field("red_out", exp_px.red, i_px_data[7:0]);
                    check_field("green_out", exp_px.green, i_px_data[15:8]);
                    check_field("blue_out", exp_px.blue, i_px_data[23:16]);
                    check_field("level_out", exp_px.level, i_px_data[31:24]);
                end
            end
            if (i_cfg_valid && i_cfg_ready) bright = i_cfg_data;
            if (i_cmd_valid && i_cmd_ready) predict_pixel(i_cmd_data);
        end
        o_due_count = due_px.size();
    end

endmodule

/* tb/led_breathing_effect_engine_unit_test.sv */
`timescale 1ns / 1ps

module led_breathing_effect_engine_unit_test;
    import ledb_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_THINKING = 3'd1;
    localparam logic [2:0] ST_WORKING  = 3'd2;
    localparam logic [2:0] ST_WAITING  = 3'd3;
    localparam logic [2:0] ST_SUCCESS  = 3'd4;
    localparam logic [2:0] ST_ERROR    = 3'd5;
    localparam logic [2:0] ST_SPEAKING = 3'd6;
    localparam logic [2:0] ST_SLEEPING = 3'd7;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 100;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 204;
    localparam int IDLE_PCT        = 18;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data    = '0;

    int          fail_count;
    int          due_count;
    bit          no_idle  = 1'b0;
    bit          hold_req = 1'b0;
    logic [31:0] clock_ms;

    led_breathing_effect_engine_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    led_colour_checker colour_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (s_axis_tvalid),
        .i_cmd_ready  (s_axis_tready),
        .i_cmd_data   (s_axis_tdata),
        .i_px_valid   (m_axis_tvalid),
        .i_px_ready   (m_axis_tready),
        .i_px_data    (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_due_count  (due_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random back-pressure, or one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_cmd(input logic [1:0] act, input logic [2:0] st,
                            input logic [31:0] now);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, now, st, act};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (due_count != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_brightness(input logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_cmd();
        int sel;
        sel = $urandom_range(99);
        if (sel < 6) begin
            send_cmd(ACT_SET, 3'($urandom_range(7)), clock_ms);
        end else if (sel < 11) begin
            send_cmd(ACT_START, 3'($urandom_range(7)), clock_ms);
        end else if (sel < 15) begin
            send_cmd(ACT_UNUSED, 3'($urandom_range(7)), $urandom);
        end else if (sel < 20) begin
            clock_ms = $urandom;
            send_cmd(ACT_TICK, 3'($urandom_range(7)), clock_ms);
        end else begin
            clock_ms = clock_ms + $urandom_range(90);
            send_cmd(ACT_TICK, 3'($urandom_range(7)), clock_ms);
        end
    endtask

    function automatic logic [7:0] phase_brightness(input int p);
        case (p)
            0:       return 8'd0;
            1:       return 8'd255;
            3:       return 8'd1;
            5:       return 8'd128;
            6:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_brightness(8'd255);

        send_cmd(ACT_TICK, ST_THINKING, 32'd0);            // tick before start
        send_cmd(ACT_UNUSED, ST_SLEEPING, 32'hFFFF_FFFF);
        send_cmd(ACT_START, ST_IDLE, 32'd0);
        send_cmd(ACT_TICK, ST_IDLE, 32'hFFFF_FFFF);
        send_cmd(ACT_SET, ST_THINKING, 32'hFFFF_FF00);
        send_cmd(ACT_TICK, ST_IDLE, 32'hFFFF_FF00);        // floor level
        send_cmd(ACT_TICK, ST_IDLE, 32'hFFFF_FF00 + 32'd1300); // peak, across wrap
        send_cmd(ACT_TICK, ST_IDLE, 32'hFFFF_FF00 + 32'd2599);
        send_cmd(ACT_SET, ST_WORKING, 32'd7);              // same look, timer kept
        send_cmd(ACT_TICK, ST_IDLE, 32'hFFFF_FF00 + 32'd750);
        send_cmd(ACT_SET, ST_WAITING, 32'd1000);
        send_cmd(ACT_TICK, ST_IDLE, 32'd2100);
        send_cmd(ACT_SET, ST_SUCCESS, 32'd5000);
        send_cmd(ACT_TICK, ST_IDLE, 32'd5000);
        send_cmd(ACT_TICK, ST_IDLE, 32'd6600);
        send_cmd(ACT_SET, ST_ERROR, 32'd9000);
        send_cmd(ACT_TICK, ST_IDLE, 32'd9224);             // last blink-on ms
        send_cmd(ACT_TICK, ST_IDLE, 32'd9225);
        send_cmd(ACT_TICK, ST_IDLE, 32'd9899);
        send_cmd(ACT_SET, ST_SPEAKING, 32'd12000);
        send_cmd(ACT_TICK, ST_IDLE, 32'd12001);
        send_cmd(ACT_START, ST_IDLE, 32'd13000);
        send_cmd(ACT_SET, ST_SLEEPING, 32'd14000);
        send_cmd(ACT_SET, ST_IDLE, 32'd14001);             // same look as sleeping
        send_cmd(ACT_TICK, ST_IDLE, 32'd14002);

        for (int p = 0; p < PHASES; p++) begin
            drain_pixels();
            write_brightness(phase_brightness(p));
            no_idle  = (p == 4);
            clock_ms = (p == 3) ? 32'hFFFF_F800 : $urandom;
            if (p == 2) hold_req = 1'b1;
            send_cmd(ACT_SET, 3'($urandom_range(7)), clock_ms);
            send_cmd(ACT_START, 3'($urandom_range(7)), clock_ms);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) random_cmd();
        end
        no_idle = 1'b0;

        drain_pixels();
        if (fail_count == 0 && due_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
